// ===== rtl/kalman_angle_gyro_fusion_assert.svh =====
// ----------------------------------------------------------------------------
// kalman angle gyro fusion assertion macros
// shared property wrappers for the filter checks
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_GYRO_FUSION_ASSERT_SVH
`define KALMAN_ANGLE_GYRO_FUSION_ASSERT_SVH

// same-cycle implication
`define KAGF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kagf assertion failed");

// next-cycle implication
`define KAGF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kagf assertion failed");

`endif

// ===== rtl/kagf_pkg.sv =====
// ----------------------------------------------------------------------------
// kagf_pkg
// types, codes and helpers for the angle/gyro kalman filter
// ----------------------------------------------------------------------------
package kagf_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 68;

   // configuration register indexes
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] REG_STEP_TIME   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB,
      ST_ERR,
      ST_DIV_SET,
      ST_DIV,
      ST_DIV_END,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_PREDICT,
      OP_AA_GROW,
      OP_CROSS_GROW,
      OP_BB_GROW,
      OP_AA_SHRINK,
      OP_AB_SHRINK,
      OP_BA_SHRINK,
      OP_BB_SHRINK,
      OP_ANGLE_CORR,
      OP_BIAS_CORR
   } op_type;

   // clamp a wide signed value to the 32 bit signed range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'(32'sh7fffffff));
      lo = ACC_W'(signed'(32'sh80000000));
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

// ===== rtl/kalman_angle_gyro_fusion.sv =====
// ----------------------------------------------------------------------------
// kalman_angle_gyro_fusion
// two-state kalman filter fusing accelerometer tilt with gyro rate
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  req      in         req_valid / req_stall     req_angle_meas, req_gyro_meas
//  rsp      out        rsp_valid / rsp_stall     rsp_angle_est, rsp_rate_est,
//                                                rsp_bias_est
//  csr      in/out     apb style, pready tied    four registers (31/25 bit)
//
//  the two gain divisions run one quotient bit a cycle through the shared
//  restoring divider, and ten multiply ops share one multiplier
//  req_stall is high from acceptance until the result is loaded into the
//  output register; a waiting result does not block the next request
//  synchronous reset restores the filter state and register defaults
// ----------------------------------------------------------------------------
`include "kalman_angle_gyro_fusion_assert.svh"

module kalman_angle_gyro_fusion
   import kagf_pkg::*;
#(
   parameter int COV_FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_angle_meas,
   input  logic signed [31:0] req_gyro_meas,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_angle_est,
   output logic signed [31:0] rsp_rate_est,
   output logic signed [31:0] rsp_bias_est,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // dividend width: |num| below 2^32, shifted up by the covariance fraction
   localparam int NW    = DATA_W + COV_FRAC_BITS;
   localparam int CNT_W = $clog2(NW);
   localparam int MA_W  = 34;
   localparam int MB_W  = 33;
   localparam int PR_W  = MA_W + MB_W;
   localparam logic signed [31:0] COV_ONE = 32'sd1 <<< COV_FRAC_BITS;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [30:0] angle_noise_ff, bias_noise_ff, meas_noise_ff;
   logic [24:0] step_time_ff;

   logic signed [31:0] meas_ff, meas_in, gyro_ff, gyro_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [31:0] err_ff, err_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic signed [PR_W-1:0] prod_ff, prod_in;

   // divider
   logic [31:0]      e_ff, e_in, rem_ff, rem_in;
   logic [NW-1:0]    nq_ff, nq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in, sel_ff, sel_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in;
   logic signed [31:0] rsp_rate_ff, rsp_rate_in;
   logic signed [31:0] rsp_bias_ff, rsp_bias_in;

   logic req_acc, csr_wr;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [PR_W-1:0] prod_sh;
   logic signed [MB_W-1:0] dt_s;
   logic signed [32:0]     rate_s;
   logic signed [31:0]     wb_dest;
   logic                   wb_sub;
   logic signed [ACC_W-1:0] wb_sum, wb_sum2;
   logic signed [33:0]     e_s;
   logic signed [31:0]     div_num;
   logic [31:0]            div_mag;
   logic [32:0]            trial;
   logic                   trial_ge;
   logic signed [31:0]     q_sat;

   assign req_acc    = req_valid && !req_stall;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff <= 31'd1678;
         bias_noise_ff  <= 31'd50332;
         meas_noise_ff  <= 31'd8388608;
         step_time_ff   <= 25'd83886;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_ANGLE_NOISE: angle_noise_ff <= csr_pwdata[30:0];
            REG_BIAS_NOISE:  bias_noise_ff  <= csr_pwdata[30:0];
            REG_MEAS_NOISE:  meas_noise_ff  <= csr_pwdata[30:0];
            REG_STEP_TIME:   step_time_ff   <= csr_pwdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ANGLE_NOISE: csr_prdata = {1'b0, angle_noise_ff};
         REG_BIAS_NOISE:  csr_prdata = {1'b0, bias_noise_ff};
         REG_MEAS_NOISE:  csr_prdata = {1'b0, meas_noise_ff};
         REG_STEP_TIME:   csr_prdata = {7'd0, step_time_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      dt_s   = signed'({8'd0, step_time_ff});
      rate_s = 33'(gyro_ff) - 33'(bias_ff);
      mul_a  = '0;
      mul_b  = '0;
      unique case (op_ff)
         OP_PREDICT: begin
            mul_a = MA_W'(rate_s);
            mul_b = dt_s;
         end
         OP_AA_GROW: begin
            // growth uses the old cross terms
            mul_a = MA_W'(signed'({1'b0, angle_noise_ff})) - MA_W'(ab_ff) - MA_W'(ba_ff);
            mul_b = dt_s;
         end
         OP_CROSS_GROW: begin
            mul_a = -MA_W'(bb_ff);
            mul_b = dt_s;
         end
         OP_BB_GROW: begin
            mul_a = MA_W'(signed'({1'b0, bias_noise_ff}));
            mul_b = dt_s;
         end
         OP_AA_SHRINK: begin
            mul_a = MA_W'(k0_ff);
            mul_b = MB_W'(t0_ff);
         end
         OP_AB_SHRINK: begin
            mul_a = MA_W'(k0_ff);
            mul_b = MB_W'(t1_ff);
         end
         OP_BA_SHRINK: begin
            mul_a = MA_W'(k1_ff);
            mul_b = MB_W'(t0_ff);
         end
         OP_BB_SHRINK: begin
            mul_a = MA_W'(k1_ff);
            mul_b = MB_W'(t1_ff);
         end
         OP_ANGLE_CORR: begin
            mul_a = MA_W'(k0_ff);
            mul_b = MB_W'(err_ff);
         end
         OP_BIAS_CORR: begin
            mul_a = MA_W'(k1_ff);
            mul_b = MB_W'(err_ff);
         end
         default: ;
      endcase
      prod_in = PR_W'(mul_a) * PR_W'(mul_b);
   end

   // write-back add or subtract: arithmetic shift gives the floor
   always_comb begin
      prod_sh = prod_ff >>> COV_FRAC_BITS;
      wb_dest = aa_ff;
      wb_sub  = 1'b0;
      unique case (op_ff)
         OP_PREDICT:    wb_dest = angle_ff;
         OP_AA_GROW:    wb_dest = aa_ff;
         OP_CROSS_GROW: wb_dest = ab_ff;
         OP_BB_GROW:    wb_dest = bb_ff;
         OP_AA_SHRINK:  begin wb_dest = aa_ff; wb_sub = 1'b1; end
         OP_AB_SHRINK:  begin wb_dest = ab_ff; wb_sub = 1'b1; end
         OP_BA_SHRINK:  begin wb_dest = ba_ff; wb_sub = 1'b1; end
         OP_BB_SHRINK:  begin wb_dest = bb_ff; wb_sub = 1'b1; end
         OP_ANGLE_CORR: wb_dest = angle_ff;
         OP_BIAS_CORR:  wb_dest = bias_ff;
         default: ;
      endcase
      wb_sum  = wb_sub ? ACC_W'(wb_dest) - ACC_W'(prod_sh)
                       : ACC_W'(wb_dest) + ACC_W'(prod_sh);
      wb_sum2 = ACC_W'(ba_ff) + ACC_W'(prod_sh);
   end

   // divider helpers
   always_comb begin
      e_s      = 34'(signed'({1'b0, meas_noise_ff})) + 34'(aa_ff);
      div_num  = sel_ff ? ba_ff : aa_ff;
      div_mag  = div_num[31] ? 32'(~div_num + 32'sd1) : 32'(div_num);
      trial    = {rem_ff, nq_ff[NW-1]};
      trial_ge = (trial >= {1'b0, e_ff});
      if (neg_ff) begin
         if (nq_ff > NW'(33'h080000000)) begin
            q_sat = 32'sh80000000;
         end else begin
            q_sat = signed'(~nq_ff[31:0] + 32'd1);
         end
      end else begin
         if (nq_ff > NW'(32'h7fffffff)) begin
            q_sat = 32'sh7fffffff;
         end else begin
            q_sat = signed'(nq_ff[31:0]);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      meas_in      = meas_ff;
      gyro_in      = gyro_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      aa_in        = aa_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      err_in       = err_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      e_in         = e_ff;
      rem_in       = rem_ff;
      nq_in        = nq_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_angle_in = rsp_angle_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_bias_in  = rsp_bias_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               meas_in  = req_angle_meas;
               gyro_in  = req_gyro_meas;
               op_in    = OP_PREDICT;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            state_in = ST_MUL;
            unique case (op_ff)
               OP_PREDICT: begin
                  angle_in = sat32(wb_sum);
                  state_in = ST_ERR;
               end
               OP_AA_GROW: begin
                  aa_in = sat32(wb_sum);
                  op_in = OP_CROSS_GROW;
               end
               OP_CROSS_GROW: begin
                  ab_in = sat32(wb_sum);
                  ba_in = sat32(wb_sum2);
                  op_in = OP_BB_GROW;
               end
               OP_BB_GROW: begin
                  bb_in    = sat32(wb_sum);
                  sel_in   = 1'b0;
                  state_in = ST_DIV_SET;
               end
               OP_AA_SHRINK: begin
                  aa_in = sat32(wb_sum);
                  op_in = OP_AB_SHRINK;
               end
               OP_AB_SHRINK: begin
                  ab_in = sat32(wb_sum);
                  op_in = OP_BA_SHRINK;
               end
               OP_BA_SHRINK: begin
                  ba_in = sat32(wb_sum);
                  op_in = OP_BB_SHRINK;
               end
               OP_BB_SHRINK: begin
                  bb_in = sat32(wb_sum);
                  op_in = OP_ANGLE_CORR;
               end
               OP_ANGLE_CORR: begin
                  angle_in = sat32(wb_sum);
                  op_in    = OP_BIAS_CORR;
               end
               OP_BIAS_CORR: begin
                  bias_in  = sat32(wb_sum);
                  state_in = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ERR: begin
            err_in   = sat32(ACC_W'(33'(meas_ff) - 33'(angle_ff)));
            op_in    = OP_AA_GROW;
            state_in = ST_MUL;
         end
         ST_DIV_SET: begin
            // divisor clamped to one lsb
            e_in     = (e_s < 34'sd1) ? 32'd1 : e_s[31:0];
            t0_in    = aa_ff;
            t1_in    = ab_ff;
            neg_in   = div_num[31];
            nq_in    = {div_mag, COV_FRAC_BITS'(0)};
            rem_in   = '0;
            cnt_in   = CNT_W'(NW - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? 32'(trial - {1'b0, e_ff}) : trial[31:0];
            nq_in  = {nq_ff[NW-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            if (sel_ff) begin
               k1_in    = q_sat;
               op_in    = OP_AA_SHRINK;
               state_in = ST_MUL;
            end else begin
               k0_in    = q_sat;
               sel_in   = 1'b1;
               state_in = ST_DIV_SET;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_rate_in  = sat32(ACC_W'(33'(gyro_ff) - 33'(bias_ff)));
               rsp_bias_in  = bias_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_PREDICT;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         aa_ff        <= COV_ONE;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= COV_ONE;
      end else begin
         op_ff        <= op_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      gyro_ff      <= gyro_in;
      err_ff       <= err_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      prod_ff      <= prod_in;
      e_ff         <= e_in;
      rem_ff       <= rem_in;
      nq_ff        <= nq_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_bias_ff  <= rsp_bias_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_est = rsp_angle_ff;
   assign rsp_rate_est  = rsp_rate_ff;
   assign rsp_bias_est  = rsp_bias_ff;

   // a taken request keeps the input side closed for the next cycle
   `KAGF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_acc, req_stall)
   // the divider never runs against a zero divisor
   `KAGF_ASSERT_IMPLY(a_div_nonzero, clock, reset, state_ff == ST_DIV, e_ff != 32'd0)
   // a new result only ever comes out of the output state
   `KAGF_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)

endmodule

// ===== dv/kagf_checker.sv =====
// ----------------------------------------------------------------------------
// kagf_checker
// watches the request, result and register ports of the kalman filter,
// keeps its own copy of the filter state and checks every result in order
// ----------------------------------------------------------------------------
module kagf_checker
   import kagf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_angle_meas,
   input  logic signed [31:0] req_gyro_meas,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_angle_est,
   input  logic signed [31:0] rsp_rate_est,
   input  logic signed [31:0] rsp_bias_est,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending,
   output int                 checked_count
);

   localparam int  FRAC = 24;
   localparam longint UNITY = longint'(1) << FRAC;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic signed [31:0] bias;
   } estimate_type;

   estimate_type estimate_q[$];

   // filter registers and state
   longint q_angle, q_bias, q_meas, dt;
   longint angle_x, bias_x, p_aa, p_ab, p_ba, p_bb;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
   end

   function automatic longint clamp_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // one filter step
   function automatic estimate_type filter_step(input logic signed [31:0] meas_in,
                                                input logic signed [31:0] gyro_in);
      longint meas, gyro, err, g0, e, k0, k1, t0, t1, aa, ab, ba, bb;
      estimate_type r;
      meas = meas_in;
      gyro = gyro_in;
      angle_x = clamp_word(angle_x + (((gyro - bias_x) * dt) >>> FRAC));
      err = clamp_word(meas - angle_x);
      g0 = q_angle - p_ab - p_ba;
      aa = clamp_word(p_aa + ((g0 * dt) >>> FRAC));
      ab = clamp_word(p_ab + ((-p_bb * dt) >>> FRAC));
      ba = clamp_word(p_ba + ((-p_bb * dt) >>> FRAC));
      bb = clamp_word(p_bb + ((q_bias * dt) >>> FRAC));
      e = q_meas + aa;
      if (e < 1) e = 1;
      k0 = clamp_word((aa * UNITY) / e);
      k1 = clamp_word((ba * UNITY) / e);
      t0 = aa;
      t1 = ab;
      p_aa = clamp_word(aa - ((k0 * t0) >>> FRAC));
      p_ab = clamp_word(ab - ((k0 * t1) >>> FRAC));
      p_ba = clamp_word(ba - ((k1 * t0) >>> FRAC));
      p_bb = clamp_word(bb - ((k1 * t1) >>> FRAC));
      angle_x = clamp_word(angle_x + ((k0 * err) >>> FRAC));
      bias_x  = clamp_word(bias_x + ((k1 * err) >>> FRAC));
      r.angle = angle_x[31:0];
      r.rate  = 32'(clamp_word(gyro - bias_x));
      r.bias  = bias_x[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         q_angle = 1678;
         q_bias  = 50332;
         q_meas  = 8388608;
         dt      = 83886;
         angle_x = 0;
         bias_x  = 0;
         p_aa    = UNITY;
         p_ab    = 0;
         p_ba    = 0;
         p_bb    = UNITY;
         estimate_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_ANGLE_NOISE: q_angle = csr_pwdata[30:0];
               REG_BIAS_NOISE:  q_bias  = csr_pwdata[30:0];
               REG_MEAS_NOISE:  q_meas  = csr_pwdata[30:0];
               REG_STEP_TIME:   dt      = csr_pwdata[24:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (estimate_q.size() == 0) begin
               report("result with no request waiting", 0, 0);
            end else begin
               want = estimate_q.pop_front();
               checked_count++;
               if (rsp_angle_est !== want.angle) report("angle_est", rsp_angle_est, want.angle);
               if (rsp_rate_est !== want.rate) report("rate_est", rsp_rate_est, want.rate);
               if (rsp_bias_est !== want.bias) report("bias_est", rsp_bias_est, want.bias);
            end
         end
         if (req_valid && !req_stall) estimate_q.push_back(filter_step(req_angle_meas, req_gyro_meas));
      end
      pending = estimate_q.size();
   end

endmodule

// ===== dv/tb_kalman_angle_gyro_fusion.sv =====
// ----------------------------------------------------------------------------
// tb_kalman_angle_gyro_fusion
// drives angle/gyro requests and register writes into the kalman filter;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_kalman_angle_gyro_fusion
   import kagf_pkg::*;
;

   // margin after the last result before register writes
   localparam int SETTLE_CYCLES = 200;
   localparam int PHASE_ITEMS   = 75;
   localparam int HOLD_CYCLES   = 800;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_angle_meas = '0;
   logic signed [31:0] req_gyro_meas = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_angle_est, rsp_rate_est, rsp_bias_est;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int fail_count, pending, checked_count;
   int sent_count = 0;
   int setting_count = 1;
   bit hold_go = 1'b0;
   bit hold_active = 1'b0;

   // clock, 12 units per period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   kalman_angle_gyro_fusion u_top (.*);

   kagf_checker u_checker (.*);

   // request field values: small, realistic, extremes and full random
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         3: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
         default: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      endcase
   endfunction

   // one apb write: setup then access
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one request and wait for it to be taken; valid stays up if asked
   task automatic offer(input logic [31:0] angle, input logic [31:0] gyro, input bit keep);
      req_valid      <= 1'b1;
      req_angle_meas <= angle;
      req_gyro_meas  <= gyro;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (!keep) req_valid <= 1'b0;
   endtask

   // random bursts with random gaps between them
   task automatic run_bursts(input int count);
      int left, len, gap;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         if (len > left) len = left;
         for (int k = 0; k < len; k++) offer(pick_word(), pick_word(), k != len - 1);
         left -= len;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         repeat (gap) @(posedge clock);
      end
   endtask

   // block must be idle before any register write
   task automatic settle();
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] m, input logic [31:0] s);
      settle();
      write_reg(REG_ANGLE_NOISE, a);
      write_reg(REG_BIAS_NOISE, b);
      write_reg(REG_MEAS_NOISE, m);
      write_reg(REG_STEP_TIME, s);
      setting_count++;
   endtask

   // result side: stalls in patterns of its own, plus one long hold-off
   initial begin
      int mode, len;
      forever begin
         if (hold_go && !hold_active) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 40);
         for (int k = 0; k < len; k++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= k[2];
            endcase
            @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      #12000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at the reset settings, with saturation
      offer(32'h0, 32'h0, 1'b0);
      offer(32'h7fffffff, 32'h7fffffff, 1'b1);
      offer(32'h7fffffff, 32'h7fffffff, 1'b1);
      offer(32'h80000000, 32'h80000000, 1'b1);
      offer(32'h80000000, 32'h80000000, 1'b0);
      offer(32'h7fffffff, 32'h80000000, 1'b0);
      offer(32'h80000000, 32'h7fffffff, 1'b1);
      offer(32'hffffffff, 32'h00000001, 1'b1);
      offer(32'h00010000, 32'hffff0000, 1'b1);
      offer(32'h00000001, 32'hffffffff, 1'b0);
      run_bursts(PHASE_ITEMS);

      // minimum noise and step time, smallest divisor
      load_setting(32'h0, 32'h0, 32'h1, 32'h1);
      offer(32'h7fffffff, 32'h80000000, 1'b0);
      offer(32'h80000000, 32'h7fffffff, 1'b0);
      run_bursts(PHASE_ITEMS);

      // maximum noise settings, unit step time; long receiver hold-off fills the block up
      load_setting(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd16777216);
      hold_go = 1'b1;
      wait (hold_active);
      run_bursts(6);
      run_bursts(PHASE_ITEMS);

      // zero step time freezes the prediction
      load_setting($urandom(), $urandom(), $urandom_range(1, 32'h7fffffff), 32'h0);
      run_bursts(PHASE_ITEMS);

      // raw 32 bit writes exercise the register width masking
      load_setting($urandom(), $urandom(), $urandom(), $urandom());
      run_bursts(PHASE_ITEMS);

      // near defaults with a tight measurement noise
      load_setting(32'd1678, 32'd50332, 32'd1000, 32'd83886);
      run_bursts(PHASE_ITEMS);

      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests over %0d register settings", sent_count,
               setting_count);
      $display("%0d results checked, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
